// ===== rtl/decimal_text_to_signed_int_unit_defines.svh =====
// Assertion macros for the checker file of this block.
`ifndef DECIMAL_TEXT_TO_SIGNED_INT_UNIT_DEFINES_SVH
`define DECIMAL_TEXT_TO_SIGNED_INT_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define DTSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define DTSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dtsi_pkg.sv =====
`timescale 1ns / 1ps

package dtsi_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Range limits, sign-extended to 64 bits, and their quotients by ten
  // (truncated toward zero).
  localparam logic signed [63:0] MIN64       = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MIN32       = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] MIN64_DIV10 = MIN64 / 64'sd10;
  localparam logic signed [63:0] MIN32_DIV10 = MIN32 / 64'sd10;

  localparam int TDATA_OUT_W = 72;

  typedef struct packed {
    logic signed [63:0] acc;
    logic               is_negative;
    logic               at_first;
    logic               seen_digit;
    logic               overflowed;
    logic               malformed;
  } parse_state_t;

  localparam parse_state_t PARSE_STATE_RESET = '{
    acc:         64'sd0,
    is_negative: 1'b0,
    at_first:    1'b1,
    seen_digit:  1'b0,
    overflowed:  1'b0,
    malformed:   1'b0
  };

endpackage

// ===== rtl/dtsi_step.sv =====
`timescale 1ns / 1ps

// One character of parsing: next parse state and, for the final
// character, the result value and status.
module dtsi_step
  import dtsi_pkg::*;
(
  input  parse_state_t       cur,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  input  logic               wide_mode,
  output parse_state_t       nxt,
  output logic signed [63:0] value,
  output status_t            status
);

  logic signed [63:0] lo;
  logic signed [63:0] lo_div10;
  logic signed [65:0] lo_x;
  logic signed [65:0] acc_x;
  logic signed [65:0] prod;
  logic [3:0]         digit;
  logic               is_sign;
  logic               is_digit;
  parse_state_t       upd;

  assign lo       = wide_mode ? MIN64 : MIN32;
  assign lo_div10 = wide_mode ? MIN64_DIV10 : MIN32_DIV10;
  assign lo_x     = {{2{lo[63]}}, lo};
  assign acc_x    = {{2{cur.acc[63]}}, cur.acc};
  assign digit    = 4'(char_code - CH_ZERO);
  assign is_sign  = cur.at_first && (char_code == CH_PLUS || char_code == CH_MINUS);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  // acc*10 - digit as shift-add, two guard bits so nothing wraps.
  assign prod     = (acc_x <<< 3) + (acc_x <<< 1) - $signed({62'd0, digit});

  always_comb begin
    upd          = cur;
    upd.at_first = 1'b0;
    if (is_sign) begin
      upd.is_negative = (char_code == CH_MINUS);
      if (last_char) begin
        upd.malformed = 1'b1;
      end
    end else if (is_digit) begin
      upd.seen_digit = 1'b1;
      if (!cur.overflowed) begin
        if (cur.acc < lo_div10) begin
          upd.overflowed = 1'b1;
        end else if (prod < lo_x) begin
          upd.overflowed = 1'b1;
        end else begin
          upd.acc = prod[63:0];
        end
      end
    end else begin
      upd.malformed = 1'b1;
    end

    value  = 64'sd0;
    status = ST_OK;
    if (upd.malformed || !upd.seen_digit) begin
      status = ST_MALFORMED;
    end else if (upd.overflowed || upd.acc < lo) begin
      status = ST_OVERFLOW;
    end else if (upd.is_negative) begin
      value = upd.acc;
    end else if (upd.acc == lo) begin
      status = ST_OVERFLOW;
    end else begin
      value = -upd.acc;
    end

    nxt = last_char ? PARSE_STATE_RESET : upd;
  end

endmodule

// ===== rtl/decimal_text_to_signed_int_unit.sv =====
`timescale 1ns / 1ps

// Decimal text to signed integer converter.
// The input stream carries one ASCII character per transaction in
// in_tdata[7:0]; in_tlast marks the final character of a number. An
// optional leading '+' or '-' sets the sign. On the final character one
// transaction leaves on the output stream: value in out_tdata[63:0] and
// status in out_tdata[65:64] (ok, overflow or malformed); value is zero
// unless the status is ok. Characters that are not final produce nothing.
// The cfg channel writes wide_mode: 0 checks the result against the 32-bit
// signed range, 1 against the 64-bit range. cfg_ready is always high.
// Throughput is one character per cycle, except that a final character
// waits while a result is stalled; the limit is the accumulator loop, a
// shift-add multiply by ten, a subtract and a range compare per cycle.
// Path: input register, then the parse step that loads the output register.
// Reset (synchronous, rst_n low) empties both registers, clears the parse
// state and sets wide_mode to 1. When the receiver stalls, the result
// waits in the output register; non-final characters keep flowing, and a
// final character waits in the input register until the output frees.
module decimal_text_to_signed_int_unit
  import dtsi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] char_code
  input  logic                   in_tlast,   // last_char
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,  // [63:0] value, [65:64] status, rest zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_data    // wide_mode
);

  // Input register.
  logic               in_valid_r, in_valid_nxt;
  logic [7:0]         in_char_r;
  logic               in_last_r;

  // Parse state carried from character to character.
  parse_state_t       state_r, state_nxt;
  parse_state_t       step_state;
  logic               wide_mode_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_value_r;
  status_t            out_status_r;

  logic signed [63:0] step_value;
  status_t            step_status;
  logic               out_free;
  logic               step_fire;
  logic               in_take;

  dtsi_step u_step (
    .cur       (state_r),
    .char_code (in_char_r),
    .last_char (in_last_r),
    .wide_mode (wide_mode_r),
    .nxt       (step_state),
    .value     (step_value),
    .status    (step_status)
  );

  // A final character may only step when the output register can take
  // its result; other characters step whenever they are present.
  assign out_free  = !out_valid_r || out_tready;
  assign step_fire = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || step_fire;
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (step_fire ? 1'b0 : in_valid_r);
    state_nxt    = step_fire ? step_state : state_r;
    if (step_fire && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= PARSE_STATE_RESET;
      wide_mode_r <= 1'b1;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        wide_mode_r <= cfg_data[0];
      end
    end
  end

  // Payload registers: loaded only on a transaction, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step_fire && in_last_r) begin
      out_value_r  <= step_value;
      out_status_r <= step_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_OUT_W - 66){1'b0}}, out_status_r, out_value_r};

endmodule

// ===== rtl/dtsi_checker.sv =====
`timescale 1ns / 1ps
`include "decimal_text_to_signed_int_unit_defines.svh"

module dtsi_checker
  import dtsi_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [TDATA_OUT_W-1:0] out_tdata
);

  logic [1:0]  out_status;
  logic [63:0] out_value;
  logic        out_error;
  logic        out_stall;

  assign out_status = out_tdata[65:64];
  assign out_value  = out_tdata[63:0];
  assign out_error  = (out_status != ST_OK);
  assign out_stall  = out_tvalid && !out_tready;

  `DTSI_ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_tvalid, "output valid after reset")
  `DTSI_ASSERT(a_status_known, out_tvalid |-> out_status <= ST_MALFORMED, "unknown status code")
  `DTSI_ASSERT(a_error_value_zero, out_tvalid && out_error |-> out_value == '0, "nonzero error value")
  `DTSI_ASSERT(a_stall_holds, out_stall |=> out_tvalid && $stable(out_tdata), "result changed in stall")

endmodule

bind decimal_text_to_signed_int_unit dtsi_checker u_dtsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dtsi_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 4;     // two-stage pipe plus margin
  localparam int SEGMENT_CHARS = 250;   // six segments and the directed rows make about 1700

  // Range floors of the two widths and the 64-bit ceiling, as 64-bit signed numbers.
  localparam longint FLOOR64 = 64'sh8000_0000_0000_0000;
  localparam longint FLOOR32 = -64'sd2147483648;
  localparam longint CEIL64  = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    longint  value;
    status_t status;
  } parsed_number_t;

  // One directed number: its text, the width it starts in, the character index
  // before which the width flips (-1 for none) and, where it is obvious, the
  // result typed in by hand.
  typedef struct {
    string   text;
    bit      wide;
    int      flip_at;
    bit      typed;
    longint  value;
    status_t status;
  } number_case_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;     // [7:0] char_code
  logic                   in_tlast   = 1'b0;   // last_char
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] out_tdata;           // [63:0] value, [65:64] status
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_data   = 1'b1;   // wide_mode

  decimal_text_to_signed_int_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Parser state as the block should hold it.
  bit     wide      = 1'b1;
  longint neg_acc   = 0;
  bit     negative  = 1'b0;
  bit     at_first  = 1'b1;
  bit     got_digit = 1'b0;
  bit     too_big   = 1'b0;
  bit     bad_text  = 1'b0;

  parsed_number_t expected_numbers[$];
  parsed_number_t oldest_number;
  int             mismatches     = 0;
  int             cycle_count    = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             chars_sent     = 0;
  number_case_t   directed_cases[24];

  // Consume one character; returns 1 with the parsed number on the final one.
  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output longint val, output status_t st);
    longint floor_v;
    longint scaled;
    longint digit;
    floor_v = wide ? FLOOR64 : FLOOR32;
    val = 0;
    st  = ST_OK;
    if (at_first && (c == CH_PLUS || c == CH_MINUS)) begin
      negative = (c == CH_MINUS);
      if (last) bad_text = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = c - CH_ZERO;
      got_digit = 1'b1;
      // The magnitude grows downward so the range floor itself is reachable.
      if (!too_big) begin
        if (neg_acc < floor_v / 10) begin
          too_big = 1'b1;
        end else begin
          scaled = neg_acc * 10;
          if (scaled < floor_v + digit) too_big = 1'b1;
          else neg_acc = scaled - digit;
        end
      end
    end else begin
      bad_text = 1'b1;
    end
    at_first = 1'b0;
    if (!last) return 1'b0;

    if (bad_text || !got_digit) begin
      st = ST_MALFORMED;
    end else if (too_big || neg_acc < floor_v) begin
      st = ST_OVERFLOW;
    end else if (negative) begin
      val = neg_acc;
    end else if (neg_acc == floor_v) begin
      st = ST_OVERFLOW;   // a positive number cannot reach the floor's magnitude
    end else begin
      val = -neg_acc;
    end
    neg_acc   = 0;
    negative  = 1'b0;
    at_first  = 1'b1;
    got_digit = 1'b0;
    too_big   = 1'b0;
    bad_text  = 1'b0;
    return 1'b1;
  endfunction

  // Offer one character, with random idle cycles ahead of it. Called just after
  // a rising edge; returns just after the edge that accepted the transaction.
  task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                           input longint typed_val, input status_t typed_st);
    bit             idled;
    parsed_number_t result;
    idled = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!idled) in_tvalid <= 1'b0;
      idled = 1'b1;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    if (parse_char(c, last, result.value, result.status)) begin
      if (typed) begin
        result.value  = typed_val;
        result.status = typed_st;
      end
      expected_numbers.push_back(result);
    end
  endtask

  // Let every expected number come out, then let the pipe empty of characters
  // that produce nothing.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    wide = mode;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed numbers with random digits, some near the range floor,
  // plus broken numbers and raw byte noise.
  task automatic send_random_number();
    logic [7:0] txt[$];
    string      floor_digits;
    int         kind;
    int         n;
    int         pos;
    kind = $urandom_range(99);
    if (kind < 85) begin
      case ($urandom_range(2))
        1: txt.push_back(CH_PLUS);
        2: txt.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(4) == 0) begin
        if (wide) floor_digits = "9223372036854775808";
        else floor_digits = "2147483648";
        for (int i = 0; i < floor_digits.len(); i++) txt.push_back(floor_digits[i]);
        txt[txt.size() - 1] = 8'(CH_ZERO + $urandom_range(9));
        if ($urandom_range(3) == 0) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      end else begin
        n = ($urandom_range(3) == 0) ? $urandom_range(12, 21) : $urandom_range(1, 11);
        repeat (n) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      if (kind >= 70) begin
        if ($urandom_range(7) == 0) begin
          txt.delete();
          txt.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        end else begin
          pos = $urandom_range(txt.size());
          if ($urandom_range(1)) txt.insert(pos, $urandom_range(1) ? CH_PLUS : CH_MINUS);
          else txt.insert(pos, 8'($urandom_range(255)));
        end
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) txt.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < txt.size(); i++)
      send_char(txt[i], i == txt.size() - 1, 1'b0, 0, ST_OK);
  endtask

  // Result side: compare every transaction with the oldest expected number and
  // stall at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_numbers.size() == 0) begin
        $error("unexpected result: value %0d, status %0d",
               $signed(out_tdata[63:0]), out_tdata[65:64]);
        mismatches++;
      end else begin
        oldest_number = expected_numbers.pop_front();
        if (out_tdata[63:0] !== oldest_number.value) begin
          $error("value: expected %0d, actual %0d",
                 oldest_number.value, $signed(out_tdata[63:0]));
          mismatches++;
        end
        if (out_tdata[65:64] !== oldest_number.status) begin
          $error("status: expected %0d, actual %0d",
                 oldest_number.status, out_tdata[65:64]);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    number_case_t row;
    int           len;
    directed_cases = '{
      '{"0",                     1'b1, -1, 1'b1, 0,        ST_OK},
      '{"+0",                    1'b1, -1, 1'b1, 0,        ST_OK},
      '{"-0",                    1'b1, -1, 1'b1, 0,        ST_OK},
      '{"9223372036854775807",   1'b1, -1, 1'b1, CEIL64,   ST_OK},
      '{"-9223372036854775808",  1'b1, -1, 1'b1, FLOOR64,  ST_OK},
      '{"9223372036854775808",   1'b1, -1, 1'b1, 0,        ST_OVERFLOW},
      '{"-9223372036854775809",  1'b1, -1, 1'b1, 0,        ST_OVERFLOW},
      '{"99999999999999999999",  1'b1, -1, 1'b1, 0,        ST_OVERFLOW},
      '{"+",                     1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"-",                     1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"1-2",                   1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"--5",                   1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"12\377",                1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"/",                     1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{":",                     1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"99999999999999999999x", 1'b1, -1, 1'b1, 0,        ST_MALFORMED},
      '{"-3000000000",           1'b1, 10, 1'b0, 0,        ST_OK},
      '{"2147483647",            1'b0, -1, 1'b1, 64'sd2147483647, ST_OK},
      '{"-2147483648",           1'b0, -1, 1'b1, FLOOR32,  ST_OK},
      '{"2147483648",            1'b0, -1, 1'b1, 0,        ST_OVERFLOW},
      '{"-2147483649",           1'b0, -1, 1'b1, 0,        ST_OVERFLOW},
      '{"007",                   1'b0, -1, 1'b1, 7,        ST_OK},
      '{"-42",                   1'b0, -1, 1'b0, 0,        ST_OK},
      '{"5000000000",            1'b0,  5, 1'b0, 0,        ST_OK}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed numbers; the first rows run in the width left by reset.
    send_idle_pct  = 10;
    recv_stall_pct = 69;
    foreach (directed_cases[k]) begin
      row = directed_cases[k];
      len = row.text.len();
      if (row.wide != wide) begin
        drain_results();
        write_mode(row.wide);
      end
      for (int j = 0; j < len; j++) begin
        // Width flips between two characters of one number.
        if (j == row.flip_at) begin
          drain_results();
          write_mode(!wide);
        end
        send_char(row.text[j], j == len - 1, row.typed, row.value, row.status);
      end
    end

    // Random numbers: receiver-side stalling, then sender-side idling, then none, each
    // in both widths. Every width change waits for an empty pipe.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 69 : 0;
      recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 10 : 0;
      for (int seg = 0; seg < 2; seg++) begin
        drain_results();
        write_mode((phase + seg) % 2 == 0);
        chars_sent = 0;
        while (chars_sent < SEGMENT_CHARS) send_random_number();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dtsi_pkg.sv
rtl/dtsi_step.sv
rtl/decimal_text_to_signed_int_unit.sv
rtl/dtsi_checker.sv
dv/tb.sv
